### rtl/fce_pkg.sv
// shared constants, types and register codes for the feedback comb echo
package fce_pkg;

   localparam int RING_DEPTH    = 16384;
   localparam int SAMPLE_BITS   = 24;
   localparam int MIX_BITS      = 24;
   localparam int GAIN_BITS     = 13;
   localparam int DELAY_BITS    = 14;
   localparam int COEF_SHIFT    = 12;
   localparam int OUT_BITS      = 16;
   localparam int OUT_SHIFT     = SAMPLE_BITS - OUT_BITS;
   localparam int ADDR_BITS     = $clog2(RING_DEPTH);
   localparam int TAP_SUM_BITS  = ((ADDR_BITS > DELAY_BITS) ? ADDR_BITS : DELAY_BITS) + 1;
   localparam int PROD_IN_BITS  = MIX_BITS + GAIN_BITS;
   localparam int PROD_FB_BITS  = SAMPLE_BITS + GAIN_BITS;
   localparam int SUM_BITS      =
      ((PROD_IN_BITS > PROD_FB_BITS) ? PROD_IN_BITS : PROD_FB_BITS) - COEF_SHIFT + 1;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 14;

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(RING_DEPTH - 1);

   localparam logic signed [GAIN_BITS-1:0]  INPUT_GAIN_RESET    = GAIN_BITS'(4095);
   localparam logic signed [GAIN_BITS-1:0]  FEEDBACK_GAIN_RESET = GAIN_BITS'(0);
   localparam logic [DELAY_BITS-1:0]        DELAY_LENGTH_RESET  = DELAY_BITS'(0);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_INPUT_GAIN    = 2'd0,
      REG_FEEDBACK_GAIN = 2'd1,
      REG_DELAY_LENGTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0] input_gain;
      logic signed [GAIN_BITS-1:0] feedback_gain;
      logic [DELAY_BITS-1:0]       delay_length;
   } cfg_type;

   typedef struct packed {
      logic                 clearing;
      logic [ADDR_BITS-1:0] head;
      logic [ADDR_BITS-1:0] tap;
   } seq_type;

   typedef struct packed {
      logic                   en;
      logic [ADDR_BITS-1:0]   addr;
      logic [SAMPLE_BITS-1:0] data;
   } ram_wr_type;

endpackage

### rtl/fce_req_if.sv
// input sample channel
interface fce_req_if import fce_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [MIX_BITS-1:0] mix_sample;

   modport source (output valid, output mix_sample, input ready);
   modport sink   (input valid, input mix_sample, output ready);
endinterface

### rtl/fce_rsp_if.sv
// effect sample result channel
interface fce_rsp_if import fce_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] effect_sample;

   modport source (output valid, output effect_sample, input ready);
   modport sink   (input valid, input effect_sample, output ready);
endinterface

### rtl/fce_csr_if.sv
// register write channel
interface fce_csr_if import fce_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fce_ram.sv
// generic single write port, single read port ram with registered read
module fce_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fce_csr.sv
// configuration registers
module fce_csr import fce_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   fce_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            REG_INPUT_GAIN: begin
               cfg_in.input_gain = csr_chan.data[GAIN_BITS-1:0];
            end
            REG_FEEDBACK_GAIN: begin
               cfg_in.feedback_gain = csr_chan.data[GAIN_BITS-1:0];
            end
            REG_DELAY_LENGTH: begin
               cfg_in.delay_length = csr_chan.data[DELAY_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_gain    <= INPUT_GAIN_RESET;
         cfg_ff.feedback_gain <= FEEDBACK_GAIN_RESET;
         cfg_ff.delay_length  <= DELAY_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/fce_seq.sv
// write head, tap address and post-reset ring clearing sweep
module fce_seq import fce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [DELAY_BITS-1:0] delay_length,
   output seq_type               seq,
   output ram_wr_type            clr_wr
);

   logic                    clear_ff;
   logic                    clear_in;
   logic [ADDR_BITS-1:0]    clear_addr_ff;
   logic [ADDR_BITS-1:0]    clear_addr_in;
   logic [ADDR_BITS-1:0]    head_ff;
   logic [ADDR_BITS-1:0]    head_in;
   logic [TAP_SUM_BITS-1:0] tap_sum;
   logic [TAP_SUM_BITS-1:0] tap_wrap;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = ADDR_BITS'(clear_addr_ff + 1'b1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   // head walks downward, wrapping at the bottom
   always_comb begin
      head_in = head_ff;
      if (accept) begin
         head_in = (head_ff == '0) ? LAST_ADDR : ADDR_BITS'(head_ff - 1'b1);
      end
   end

   // tap sits delay_length words above the head, modulo ring depth
   always_comb begin
      tap_sum  = TAP_SUM_BITS'(head_ff) + TAP_SUM_BITS'(delay_length);
      tap_wrap = (tap_sum >= TAP_SUM_BITS'(RING_DEPTH)) ?
                 TAP_SUM_BITS'(tap_sum - TAP_SUM_BITS'(RING_DEPTH)) : tap_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         head_ff       <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         head_ff       <= head_in;
      end
   end

   assign seq.clearing = clear_ff;
   assign seq.head     = head_ff;
   assign seq.tap      = tap_wrap[ADDR_BITS-1:0];

   assign clr_wr.en   = clear_ff;
   assign clr_wr.addr = clear_addr_ff;
   assign clr_wr.data = '0;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clear_ff)
      else $error("sample transfer during ring clearing");

   a_head_moves_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(head_ff))
      else $error("write head moved without a sample transfer");

endmodule

### rtl/fce_pipe.sv
// multiply, accumulate, saturate and write-back pipeline with output register
module fce_pipe import fce_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic signed [MIX_BITS-1:0] mix_sample,
   input  seq_type                    seq,
   input  cfg_type                    cfg,
   input  logic [SAMPLE_BITS-1:0]     tap_data,
   output logic                       take_ok,
   output ram_wr_type                 pipe_wr,
   fce_rsp_if.source                  rsp_chan
);

   localparam int SCALED_IN_BITS = PROD_IN_BITS - COEF_SHIFT;
   localparam int SCALED_FB_BITS = PROD_FB_BITS - COEF_SHIFT;
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(-(2 ** (SAMPLE_BITS - 1)));

   // stage 1: ring word read in flight
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic [ADDR_BITS-1:0]           s1_head_ff;
   logic [ADDR_BITS-1:0]           s1_head_in;
   logic signed [MIX_BITS-1:0]     s1_mix_ff;
   logic signed [MIX_BITS-1:0]     s1_mix_in;
   // stage 2: products
   logic                           s2_valid_ff;
   logic                           s2_valid_in;
   logic [ADDR_BITS-1:0]           s2_head_ff;
   logic [ADDR_BITS-1:0]           s2_head_in;
   logic signed [PROD_IN_BITS-1:0] s2_pin_ff;
   logic signed [PROD_IN_BITS-1:0] s2_pin_in;
   logic signed [PROD_FB_BITS-1:0] s2_pfb_ff;
   logic signed [PROD_FB_BITS-1:0] s2_pfb_in;
   // output register
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic signed [OUT_BITS-1:0]     out_sample_ff;
   logic signed [OUT_BITS-1:0]     out_sample_in;

   logic                             s2_adv;
   logic                             s2_go;
   logic                             s1_adv;
   logic                             s1_go;
   logic                             hazard;
   logic signed [SCALED_IN_BITS-1:0] scaled_in;
   logic signed [SCALED_FB_BITS-1:0] scaled_fb;
   logic signed [SUM_BITS-1:0]       acc;
   logic signed [SAMPLE_BITS-1:0]    sat;

   always_comb begin
      s2_adv = !out_valid_ff || rsp_chan.ready;
      s2_go  = s2_valid_ff && s2_adv;
      s1_adv = !s2_valid_ff || s2_adv;
      s1_go  = s1_valid_ff && s1_adv;
      // tap word not yet written back by an older sample
      hazard = (s1_valid_ff && (s1_head_ff == seq.tap)) ||
               (s2_valid_ff && (s2_head_ff == seq.tap));
      take_ok = (!s1_valid_ff || s1_adv) && !hazard;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_head_in  = s1_head_ff;
      s1_mix_in   = s1_mix_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_head_in  = seq.head;
         s1_mix_in   = mix_sample;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_head_in  = s2_head_ff;
      s2_pin_in   = s2_pin_ff;
      s2_pfb_in   = s2_pfb_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
         s2_head_in  = s1_head_ff;
         s2_pin_in   = PROD_IN_BITS'(s1_mix_ff) * PROD_IN_BITS'(cfg.input_gain);
         s2_pfb_in   = PROD_FB_BITS'($signed(tap_data)) * PROD_FB_BITS'(cfg.feedback_gain);
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
   end

   // floor shifts, sum and clamp
   always_comb begin
      scaled_in = $signed(s2_pin_ff[PROD_IN_BITS-1:COEF_SHIFT]);
      scaled_fb = $signed(s2_pfb_ff[PROD_FB_BITS-1:COEF_SHIFT]);
      acc       = SUM_BITS'(scaled_in) + SUM_BITS'(scaled_fb);
      if (acc > SAT_HI) begin
         sat = SAT_HI[SAMPLE_BITS-1:0];
      end else if (acc < SAT_LO) begin
         sat = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat = acc[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (s2_go) begin
         out_valid_in  = 1'b1;
         out_sample_in = sat[SAMPLE_BITS-1:OUT_SHIFT];
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_head_ff    <= s1_head_in;
      s1_mix_ff     <= s1_mix_in;
      s2_head_ff    <= s2_head_in;
      s2_pin_ff     <= s2_pin_in;
      s2_pfb_ff     <= s2_pfb_in;
      out_sample_ff <= out_sample_in;
   end

   assign pipe_wr.en   = s2_go;
   assign pipe_wr.addr = s2_head_ff;
   assign pipe_wr.data = sat;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.effect_sample = out_sample_ff;

   a_stage2_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_valid_ff && !rsp_chan.ready) |=> (s2_valid_ff && $stable(s2_head_ff)))
      else $error("product stage lost its sample under output stall");

   a_heads_in_order: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |->
      (s2_head_ff == ((s1_head_ff == LAST_ADDR) ? '0 : ADDR_BITS'(s1_head_ff + 1'b1))))
      else $error("in-flight write addresses out of sequence");

   a_writeback_loads_output: assert property (@(posedge clock) disable iff (reset)
      pipe_wr.en |=> out_valid_ff)
      else $error("ring write-back without a result");

endmodule

### rtl/feedback_comb_echo.sv
// top level of the single-tap feedback comb echo
//
// Each transferred 24-bit mix sample is scaled by input_gain/4096, summed with
// the ring word delay_length samples behind the write head scaled by
// feedback_gain/4096 (both products floored), saturated to 24 bits, written
// back at the head, and delivered as the saturated value shifted right eight
// (16-bit effect sample). The head steps down by one per sample. The ring is
// a 16384 x 24 single-port-read, single-port-write RAM; after reset a clearing
// sweep zeroes it, one word per cycle, so req ready stays low until every word
// is clear (register writes are taken throughout). A sample passes through
// stage 1 (the RAM read issued on its transfer), stage 2 (the products) and the
// add/saturate/write-back into the output register, from which the rsp
// transfer is made. Samples are taken one per clock while the pipe is not held
// by a stalled output and the tap word is not still in that write-back loop:
// a delay_length of one holds each sample until the one before it is written
// back, a delay_length of two lets two samples overlap, any other delay keeps one sample per clock.
// The output register lets a new sample in while a finished result waits for
// rsp ready.
module feedback_comb_echo import fce_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fce_req_if.sink   req_chan,
   fce_rsp_if.source rsp_chan,
   fce_csr_if.sink   csr_chan
);

   cfg_type                cfg;
   seq_type                seq;
   ram_wr_type             clr_wr;
   ram_wr_type             pipe_wr;
   ram_wr_type             ram_wr;
   logic                   take_ok;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] tap_data;

   // no samples while the clearing sweep runs, the tap word is in flight or the pipe is stalled
   assign req_chan.ready = !seq.clearing && take_ok;
   assign accept         = req_chan.valid && req_chan.ready;

   // sweep owns the write port until the ring is clear
   assign ram_wr = seq.clearing ? clr_wr : pipe_wr;

   fce_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   fce_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .delay_length (cfg.delay_length),
      .seq          (seq),
      .clr_wr       (clr_wr)
   );

   // ring read issued on the sample transfer, data ready in the following cycle
   fce_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (accept),
      .rd_addr (seq.tap),
      .rd_data (tap_data)
   );

   fce_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mix_sample (req_chan.mix_sample),
      .seq        (seq),
      .cfg        (cfg),
      .tap_data   (tap_data),
      .take_ok    (take_ok),
      .pipe_wr    (pipe_wr),
      .rsp_chan   (rsp_chan)
   );

endmodule

### dv/tb_feedback_comb_echo.sv
// self-checking testbench for the feedback comb echo with its own echo predictor
module tb_feedback_comb_echo import fce_pkg::*; ();

   // run length and pacing
   localparam int SAMPLE_TARGET  = 850;
   localparam int HOLDOFF_AFTER  = 400;      // samples sent before the long rsp hold-off
   localparam int HOLDOFF_CYCLES = 200;
   localparam int DRAIN_CYCLES   = 10;       // extra clocks after the last result
   // ring clear after reset plus ~850 samples at worst-case gaps and stalls, with margin
   localparam int CYCLE_LIMIT    = 500000;

   // index past the last register, writes to it must change nothing
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE = 2'd3;

   // predictor of the echo plus the store of effect samples still owed by the block
   class comb_echo_scoreboard;
      logic signed [SAMPLE_BITS-1:0] ring_words [RING_DEPTH];
      logic [ADDR_BITS-1:0]          write_head;
      logic signed [GAIN_BITS-1:0]   dry_gain;
      logic signed [GAIN_BITS-1:0]   loop_gain;
      logic [DELAY_BITS-1:0]         tap_delay;
      logic signed [OUT_BITS-1:0]    pending_effects [$];
      int                            mismatch_count;
      int                            effects_checked;

      function new();
         foreach (ring_words[i]) ring_words[i] = '0;
         write_head      = '0;
         dry_gain        = INPUT_GAIN_RESET;
         loop_gain       = FEEDBACK_GAIN_RESET;
         tap_delay       = DELAY_LENGTH_RESET;
         mismatch_count  = 0;
         effects_checked = 0;
      endfunction

      function void apply_register(logic [CSR_IDX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_INPUT_GAIN:    dry_gain  = value[GAIN_BITS-1:0];
            REG_FEEDBACK_GAIN: loop_gain = value[GAIN_BITS-1:0];
            REG_DELAY_LENGTH:  tap_delay = value[DELAY_BITS-1:0];
            default: ;
         endcase
      endfunction

      // one accepted mix sample: read tap, mix, clamp, write back, step head down
      function void take_sample(logic signed [MIX_BITS-1:0] mix);
         logic [ADDR_BITS-1:0]          tap;
         longint                        dry;
         longint                        wet;
         longint                        acc;
         longint                        top;
         logic signed [SAMPLE_BITS-1:0] clamped;
         top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
         tap = ADDR_BITS'((longint'(write_head) + longint'(tap_delay)) % RING_DEPTH);
         dry = (longint'(mix) * longint'(dry_gain)) >>> COEF_SHIFT;
         wet = (longint'(ring_words[tap]) * longint'(loop_gain)) >>> COEF_SHIFT;
         acc = dry + wet;
         if (acc > top) acc = top;
         else if (acc < -top - 1) acc = -top - 1;
         clamped = SAMPLE_BITS'(acc);
         ring_words[write_head] = clamped;
         write_head = (write_head == '0) ? LAST_ADDR : write_head - 1'b1;
         pending_effects.push_back(OUT_BITS'(clamped >>> OUT_SHIFT));
      endfunction

      function void check_effect(logic signed [OUT_BITS-1:0] seen);
         logic signed [OUT_BITS-1:0] want;
         effects_checked++;
         if (pending_effects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected effect sample %0d, nothing pending", seen);
         end else begin
            want = pending_effects.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("effect sample %0d: expected %0d, got %0d",
                           effects_checked, want, seen);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   samples_sent = 0;
   bit   holdoff_armed = 1'b0;

   comb_echo_scoreboard echo_check;

   fce_req_if req_bus();
   fce_rsp_if rsp_bus();
   fce_csr_if csr_bus();

   feedback_comb_echo DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 2-unit clock period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // idle length shared by both sides: mostly short, now and then a long gap
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [GAIN_BITS-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return GAIN_BITS'(-4096);
      if (r < 30) return GAIN_BITS'(4095);
      return GAIN_BITS'($urandom_range(0, 8191));
   endfunction

   // register write; the predictor takes it on the transfer edge
   task automatic program_register(input logic [CSR_IDX_BITS-1:0] idx,
                                   input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      echo_check.apply_register(idx, value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // offer one mix sample, hold until transfer, then idle for gap cycles
   // (a gap of zero keeps valid high so the next call follows back to back)
   task automatic offer_sample(input logic signed [MIX_BITS-1:0] mix, input int gap);
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.mix_sample = mix;
      do @(posedge clock); while (!req_bus.ready);
      echo_check.take_sample(mix);
      samples_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // every sample yields one result, so an empty store means the block is idle
   task automatic wait_for_echoes();
      while (echo_check.pending_effects.size() != 0) @(posedge clock);
   endtask

   // all inputs known from time zero
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.mix_sample = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
   end

   // result side: random stalls, steady stretches, and one long hold-off
   initial begin : effect_sink
      int  stall_left;
      int  steady_left;
      int  r;
      bit  holdoff_done;
      stall_left   = 0;
      steady_left  = 0;
      holdoff_done = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (!holdoff_done && holdoff_armed) begin
            // sender keeps offering while this lasts, so the pipe fills and req stalls
            holdoff_done = 1'b1;
            stall_left   = HOLDOFF_CYCLES;
         end else if (stall_left == 0 && steady_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 20) steady_left = $urandom_range(20, 80);
            else if (r < 50) stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (steady_left > 0) steady_left--;
         end
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) echo_check.check_effect(rsp_bus.effect_sample);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : mix_source
      int                            r;
      int                            burst;
      bit                            no_idle;
      logic signed [MIX_BITS-1:0]    mix;
      logic [DELAY_BITS-1:0]         delay;
      echo_check = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings, spare index ignored, field extremes and floor rounding
      program_register(REG_SPARE, '1);
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh800000, 0);
      offer_sample(24'sh000000, 0);
      offer_sample(MIX_BITS'(-1), 0);
      offer_sample(24'sh000001, 0);
      offer_sample(24'sh555555, 0);
      offer_sample(24'shAAAAAA, 0);
      drop_request();
      wait_for_echoes();

      // most negative gain saturates high; full feedback at a one-sample tap
      program_register(REG_INPUT_GAIN, {1'b1, GAIN_BITS'(-4096)});
      program_register(REG_FEEDBACK_GAIN, CSR_DATA_BITS'(4095));
      program_register(REG_DELAY_LENGTH, CSR_DATA_BITS'(1));
      offer_sample(24'sh800000, 0);
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh000000, 0);
      offer_sample(24'sh000000, 0);
      offer_sample(24'sh000001, 0);
      drop_request();
      wait_for_echoes();

      // inverting feedback at a two-sample tap drives the sum past both rails
      program_register(REG_INPUT_GAIN, CSR_DATA_BITS'(4095));
      program_register(REG_FEEDBACK_GAIN, {1'b0, GAIN_BITS'(-4096)});
      program_register(REG_DELAY_LENGTH, CSR_DATA_BITS'(2));
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh800000, 0);
      offer_sample(24'sh000000, 0);
      drop_request();
      wait_for_echoes();

      // tiny gain rounds toward minus infinity; tap offsets at the top of the range wrap
      program_register(REG_INPUT_GAIN, CSR_DATA_BITS'(1));
      program_register(REG_FEEDBACK_GAIN, CSR_DATA_BITS'(4095));
      program_register(REG_DELAY_LENGTH, CSR_DATA_BITS'(16383));
      offer_sample(MIX_BITS'(-1), 0);
      offer_sample(24'sh000FFF, 0);
      offer_sample(MIX_BITS'(-4096), 0);
      drop_request();
      wait_for_echoes();
      program_register(REG_DELAY_LENGTH, CSR_DATA_BITS'(16382));
      offer_sample(24'sh7FFFFF, 0);
      offer_sample(24'sh800000, 0);
      drop_request();

      // random phases: new settings once idle, then a burst of samples
      while (samples_sent < SAMPLE_TARGET) begin
         wait_for_echoes();
         if ($urandom_range(0, 3) == 0)
            program_register(REG_SPARE, CSR_DATA_BITS'($urandom_range(0, 16383)));
         program_register(REG_INPUT_GAIN, {1'($urandom_range(0, 1)), pick_gain()});
         program_register(REG_FEEDBACK_GAIN, {1'($urandom_range(0, 1)), pick_gain()});
         // short taps keep the loop busy, mid taps echo recent output, some span the ring
         r = $urandom_range(0, 99);
         if (r < 35) delay = DELAY_BITS'($urandom_range(1, 3));
         else if (r < 75) delay = DELAY_BITS'($urandom_range(0, 300));
         else delay = DELAY_BITS'($urandom_range(0, 16383));
         program_register(REG_DELAY_LENGTH, delay);
         burst   = $urandom_range(10, 60);
         no_idle = ($urandom_range(0, 3) == 0);
         if (!holdoff_armed && samples_sent >= HOLDOFF_AFTER) begin
            // long rsp hold-off over a gapless burst
            holdoff_armed = 1'b1;
            no_idle       = 1'b1;
         end
         repeat (burst) begin
            r = $urandom_range(0, 99);
            if (r < 70) mix = MIX_BITS'($urandom());
            else if (r < 85) mix = MIX_BITS'($urandom_range(0, 511) - 256);
            else begin
               case ($urandom_range(0, 3))
                  0: mix = 24'sh7FFFFF;
                  1: mix = 24'sh800000;
                  2: mix = 24'sh000000;
                  default: mix = MIX_BITS'(-1);
               endcase
            end
            offer_sample(mix, (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_length());
         end
         drop_request();
      end

      wait_for_echoes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (echo_check.mismatch_count == 0 && echo_check.pending_effects.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
